// ----- src/rdbe_pkg.sv -----
// Shared types, constants and the control program of the drift bias estimator.
`default_nettype none

package rdbe_pkg;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned ResW      = 24;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned FocW      = 23;
  localparam int unsigned BiasW     = 32;
  localparam int unsigned MulW      = 32;
  localparam int unsigned NumW      = 96;
  localparam int unsigned DenW      = 55;
  localparam int unsigned QuoW      = 37;
  localparam int unsigned MagW      = 36;
  localparam int unsigned CntW      = 6;
  localparam int unsigned PcW       = 5;
  localparam int unsigned RateMulW  = 20;
  localparam int unsigned RateShift = 24;

  localparam logic [CfgW-1:0]     TAU_DEFAULT  = 32'd20000000;
  localparam logic [FocW-1:0]     MAXRES_RESET = 23'd1536;
  localparam logic [FocW-1:0]     FOCAL_RESET  = 23'd128000;
  localparam logic [FocW-1:0]     FOCAL_MIN    = 23'd1;
  localparam logic [MulW-1:0]     RATE_MICRO   = 32'd1000000;
  localparam logic [MagW-1:0]     MAG_CAP      = 36'h8_0000_0000;
  localparam logic [BiasW-1:0]    BIAS_MAX     = 32'h7FFF_FFFF;
  localparam logic [BiasW-1:0]    BIAS_MIN     = 32'h8000_0000;
  localparam logic [PcW-1:0]      PC_EMIT      = 5'd27;

  typedef enum logic [1:0] {
    CFG_TAU     = 2'd0,
    CFG_MAXRES  = 2'd1,
    CFG_FOCAL_X = 2'd2,
    CFG_FOCAL_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_CHECK,
    OP_MUL_TF,
    OP_MUL_RES,
    OP_LOAD_RATE,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_ACC_ONE,
    OP_DIFF,
    OP_MUL_DLO,
    OP_MUL_DHI,
    OP_ADD_HI,
    OP_ACC_TWO,
    OP_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_NO_UPD,
    JMP_DIV_BUSY,
    JMP_OUT_FULL
  } jcond_e;

  typedef struct packed {
    uop_e             op;
    logic             lane;
    jcond_e           cond;
    logic [PcW-1:0]   target;
  } uword_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_ROUND
  } div_state_e;

  // Control store. Lane 0 is the y residual / bias_x path, lane 1 the x residual / bias_y path.
  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_EMIT, lane: 1'b0, cond: JMP_NEVER, target: '0};
    case (pc)
      5'd0:  w = '{op: OP_CHECK,     lane: 1'b0, cond: JMP_NO_UPD,   target: PC_EMIT};
      5'd1:  w = '{op: OP_MUL_TF,    lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd2:  w = '{op: OP_MUL_RES,   lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd3:  w = '{op: OP_LOAD_RATE, lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd4:  w = '{op: OP_DIV_START, lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd5:  w = '{op: OP_DIV_WAIT,  lane: 1'b0, cond: JMP_DIV_BUSY, target: 5'd5};
      5'd6:  w = '{op: OP_ACC_ONE,   lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd7:  w = '{op: OP_MUL_TF,    lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd8:  w = '{op: OP_MUL_RES,   lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd9:  w = '{op: OP_LOAD_RATE, lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd10: w = '{op: OP_DIV_START, lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd11: w = '{op: OP_DIV_WAIT,  lane: 1'b1, cond: JMP_DIV_BUSY, target: 5'd11};
      5'd12: w = '{op: OP_ACC_ONE,   lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd13: w = '{op: OP_DIFF,      lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd14: w = '{op: OP_MUL_DLO,   lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd15: w = '{op: OP_MUL_DHI,   lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd16: w = '{op: OP_ADD_HI,    lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd17: w = '{op: OP_DIV_START, lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd18: w = '{op: OP_DIV_WAIT,  lane: 1'b0, cond: JMP_DIV_BUSY, target: 5'd18};
      5'd19: w = '{op: OP_ACC_TWO,   lane: 1'b0, cond: JMP_NEVER,    target: '0};
      5'd20: w = '{op: OP_DIFF,      lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd21: w = '{op: OP_MUL_DLO,   lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd22: w = '{op: OP_MUL_DHI,   lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd23: w = '{op: OP_ADD_HI,    lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd24: w = '{op: OP_DIV_START, lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd25: w = '{op: OP_DIV_WAIT,  lane: 1'b1, cond: JMP_DIV_BUSY, target: 5'd25};
      5'd26: w = '{op: OP_ACC_TWO,   lane: 1'b1, cond: JMP_NEVER,    target: '0};
      5'd27: w = '{op: OP_EMIT,      lane: 1'b0, cond: JMP_OUT_FULL, target: PC_EMIT};
      default: w = '{op: OP_EMIT,    lane: 1'b0, cond: JMP_OUT_FULL, target: PC_EMIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/rdbe_div.sv -----
// Restoring divider with round-half-up and a magnitude cap, one quotient bit per cycle.
`default_nettype none

module rdbe_div import rdbe_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [MagW-1:0]      mag_o
);

  div_state_e state_q, state_d;

  logic [DenW-1:0]      rem_q;
  logic [QuoW-1:0]      qs_q;
  logic [DenW-1:0]      den_q;
  logic [CntW-1:0]      cnt_q;
  logic [MagW-1:0]      mag_q;

  logic [NumW-QuoW-1:0] num_hi;
  logic                 ovf;
  logic [DenW:0]        r2;
  logic                 ge;
  logic [DenW:0]        r2_sub;
  logic                 rnd;
  logic [QuoW:0]        q_rnd;

  // A quotient of 2^QuoW or more is far past the cap, so the top bits alone decide it.
  assign num_hi = num_i[NumW-1:QuoW];
  assign ovf    = num_hi >= (NumW-QuoW)'(den_i);

  assign r2     = {rem_q, qs_q[QuoW-1]};
  assign ge     = r2 >= {1'b0, den_q};
  assign r2_sub = r2 - {1'b0, den_q};

  assign rnd    = {rem_q, 1'b0} >= {1'b0, den_q};
  assign q_rnd  = {1'b0, qs_q} + {{QuoW{1'b0}}, rnd};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i && !ovf) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_q == '0) begin
          state_d = DIV_ROUND;
        end
      end
      DIV_ROUND: state_d = DIV_IDLE;
      default:   state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != DIV_IDLE);
    mag_o  = mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          den_q <= den_i;
          rem_q <= num_hi[DenW-1:0];
          qs_q  <= num_i[QuoW-1:0];
          cnt_q <= CntW'(QuoW - 1);
          if (ovf) begin
            mag_q <= MAG_CAP;
          end
        end
      end
      DIV_RUN: begin
        rem_q <= ge ? r2_sub[DenW-1:0] : r2[DenW-1:0];
        qs_q  <= {qs_q[QuoW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      DIV_ROUND: begin
        mag_q <= (q_rnd > (QuoW+1)'(MAG_CAP)) ? MAG_CAP : q_rnd[MagW-1:0];
      end
      default: begin
        mag_q <= mag_q;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/residual_drift_bias_estimator.sv -----
// Top level: drift bias estimator driven by a microcoded sequencer over a shared datapath.
// An updating item runs every step, including four divisions (a quotient already past the cap
// skips its division); other items jump from the check step straight to the emit step.
// Only one item is in work at a time: the next is taken once the emit step completes, and
// the emit step waits while the result register is full and not being read.
// Reset clears the filter state and loads the register defaults; no clearing pass is needed.
`default_nettype none

module residual_drift_bias_estimator import rdbe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write port
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  // Input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [111:0]     s_axis_tdata,  // time_us, offs_x, offs_y
  input  wire logic [1:0]       s_axis_tuser,  // status_ok, rekeyed
  // Result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [63:0]           m_axis_tdata,  // bias_x, bias_y
  output logic                  m_axis_tuser   // updated
);

  // Configuration
  logic [CfgW-1:0]  tau_q;
  logic [FocW-1:0]  maxres_q, fx_q, fy_q;
  logic [CfgW-1:0]  tau_eff;
  logic [FocW-1:0]  fx_eff, fy_eff;

  // Captured beat
  logic             in_ok_q, in_rekey_q;
  logic [TimeW-1:0] in_time_q;
  logic [ResW-1:0]  in_rx_q, in_ry_q;

  // Filter state
  logic [TimeW-1:0] last_time_q;
  logic [ResW-1:0]  prev_rx_q, prev_ry_q;
  logic             have_prev_q;
  logic [BiasW-1:0] s1_q [2];
  logic [BiasW-1:0] s2_q [2];

  // Working registers
  logic             upd_q;
  logic [TimeW-1:0] dt_q;
  logic [ResW:0]    dx_q, dy_q;
  logic [2*MulW-1:0] prod_q;
  logic [DenW-1:0]  den_q;
  logic [NumW-1:0]  num_q;
  logic [BiasW-1:0] dmag_q;
  logic             dneg_q;

  // Sequencer
  logic             run_q, run_d;
  logic [PcW-1:0]   pc_q, pc_d;
  uword_t           uw;
  logic             jump;
  logic             step;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             out_upd_q;
  logic [BiasW-1:0] out_bx_q, out_by_q;
  logic             out_full;
  logic             emit_load;

  // Combinational helpers
  logic             in_good;
  logic [ResW-1:0]  rx_mag, ry_mag;
  logic             upd_now;
  logic [ResW:0]    dx_now, dy_now;
  logic [ResW:0]    dx_mag, dy_mag;
  logic [ResW:0]    d_mag_sel;
  logic             s1_neg;
  logic [BiasW:0]   d_diff;
  logic [BiasW:0]   d_diff_neg;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  logic             div_start;
  logic             div_busy;
  logic [MagW-1:0]  div_mag;
  logic             accept;

  function automatic logic [BiasW-1:0] sat_add(logic [BiasW-1:0] base, logic [MagW-1:0] mag,
                                               logic neg);
    logic [MagW+1:0] b;
    logic [MagW+1:0] m;
    logic [MagW+1:0] s;
    b = {{(MagW+2-BiasW){base[BiasW-1]}}, base};
    m = {2'b00, mag};
    s = neg ? (b - m) : (b + m);
    if (!s[MagW+1] && (s[MagW:BiasW-1] != '0)) begin
      return BIAS_MAX;
    end else if (s[MagW+1] && (s[MagW:BiasW-1] != '1)) begin
      return BIAS_MIN;
    end
    return s[BiasW-1:0];
  endfunction

  assign tau_eff = (tau_q == '0) ? TAU_DEFAULT : tau_q;
  assign fx_eff  = (fx_q == '0) ? FOCAL_MIN : fx_q;
  assign fy_eff  = (fy_q == '0) ? FOCAL_MIN : fy_q;

  assign uw     = ucode_rom(pc_q);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !run_q;

  // Item classification, evaluated in the check step
  assign in_good = in_ok_q && !in_rekey_q;
  assign rx_mag  = in_rx_q[ResW-1] ? (~in_rx_q + 1'b1) : in_rx_q;
  assign ry_mag  = in_ry_q[ResW-1] ? (~in_ry_q + 1'b1) : in_ry_q;
  assign upd_now = in_good && have_prev_q && (in_time_q > last_time_q) &&
                   (rx_mag <= {1'b0, maxres_q}) && (ry_mag <= {1'b0, maxres_q});
  assign dx_now  = {in_rx_q[ResW-1], in_rx_q} - {prev_rx_q[ResW-1], prev_rx_q};
  assign dy_now  = {in_ry_q[ResW-1], in_ry_q} - {prev_ry_q[ResW-1], prev_ry_q};

  assign dx_mag    = dx_q[ResW] ? (~dx_q + 1'b1) : dx_q;
  assign dy_mag    = dy_q[ResW] ? (~dy_q + 1'b1) : dy_q;
  assign d_mag_sel = uw.lane ? dx_mag : dy_mag;
  // Rising y residual pulls bias_x down; falling x residual pulls bias_y down.
  assign s1_neg    = uw.lane ? dx_q[ResW] : (!dy_q[ResW] && (dy_q != '0));

  assign d_diff     = {s1_q[uw.lane][BiasW-1], s1_q[uw.lane]} -
                      {s2_q[uw.lane][BiasW-1], s2_q[uw.lane]};
  assign d_diff_neg = ~d_diff + 1'b1;

  // Shared multiplier
  always_comb begin
    case (uw.op)
      OP_MUL_TF: begin
        mul_a = tau_eff;
        mul_b = {{(MulW-FocW){1'b0}}, (uw.lane ? fx_eff : fy_eff)};
      end
      OP_MUL_RES: begin
        mul_a = {{(MulW-ResW-1){1'b0}}, d_mag_sel};
        mul_b = RATE_MICRO;
      end
      OP_MUL_DLO: begin
        mul_a = dt_q[MulW-1:0];
        mul_b = dmag_q;
      end
      OP_MUL_DHI: begin
        mul_a = dt_q[TimeW-1:MulW];
        mul_b = dmag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_start = run_q && (uw.op == OP_DIV_START);

  rdbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .mag_o   (div_mag)
  );

  // Sequencer next state
  assign out_full  = out_valid_q && !m_axis_tready;
  assign step      = run_q;
  assign emit_load = run_q && (uw.op == OP_EMIT) && !out_full;

  always_comb begin
    case (uw.cond)
      JMP_NEVER:    jump = 1'b0;
      JMP_NO_UPD:   jump = !upd_now;
      JMP_DIV_BUSY: jump = div_busy;
      JMP_OUT_FULL: jump = out_full;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    run_d = run_q;
    pc_d  = pc_q;
    if (accept) begin
      run_d = 1'b1;
      pc_d  = '0;
    end else if (step) begin
      if (jump) begin
        pc_d = uw.target;
      end else if (uw.op == OP_EMIT) begin
        run_d = 1'b0;
        pc_d  = '0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q    <= TAU_DEFAULT;
      maxres_q <= MAXRES_RESET;
      fx_q     <= FOCAL_RESET;
      fy_q     <= FOCAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TAU:     tau_q    <= cfg_wdata_i;
        CFG_MAXRES:  maxres_q <= cfg_wdata_i[FocW-1:0];
        CFG_FOCAL_X: fx_q     <= cfg_wdata_i[FocW-1:0];
        CFG_FOCAL_Y: fy_q     <= cfg_wdata_i[FocW-1:0];
        default:     tau_q    <= tau_q;
      endcase
    end
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      prev_rx_q   <= '0;
      prev_ry_q   <= '0;
      have_prev_q <= 1'b0;
      s1_q[0]     <= '0;
      s1_q[1]     <= '0;
      s2_q[0]     <= '0;
      s2_q[1]     <= '0;
    end else if (run_q) begin
      case (uw.op)
        OP_CHECK: begin
          last_time_q <= in_time_q;
          have_prev_q <= in_good;
          if (in_good) begin
            prev_rx_q <= in_rx_q;
            prev_ry_q <= in_ry_q;
          end
        end
        OP_ACC_ONE: s1_q[uw.lane] <= sat_add(s1_q[uw.lane], div_mag, s1_neg);
        OP_ACC_TWO: s2_q[uw.lane] <= sat_add(s2_q[uw.lane], div_mag, dneg_q);
        default:    have_prev_q <= have_prev_q;
      endcase
    end
  end

  // Captured beat and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_time_q  <= s_axis_tdata[TimeW-1:0];
      in_rx_q    <= s_axis_tdata[TimeW+ResW-1:TimeW];
      in_ry_q    <= s_axis_tdata[TimeW+2*ResW-1:TimeW+ResW];
      in_ok_q    <= s_axis_tuser[0];
      in_rekey_q <= s_axis_tuser[1];
    end
    if (run_q) begin
      case (uw.op)
        OP_CHECK: begin
          upd_q <= upd_now;
          dt_q  <= in_time_q - last_time_q;
          dx_q  <= dx_now;
          dy_q  <= dy_now;
        end
        OP_MUL_TF:  prod_q <= mul_p;
        OP_MUL_RES: begin
          den_q  <= prod_q[DenW-1:0];
          prod_q <= mul_p;
        end
        OP_LOAD_RATE: num_q <= NumW'({prod_q[ResW+RateMulW:0], {RateShift{1'b0}}});
        OP_DIFF: begin
          dneg_q <= d_diff[BiasW];
          dmag_q <= d_diff[BiasW] ? d_diff_neg[BiasW-1:0] : d_diff[BiasW-1:0];
          den_q  <= DenW'(tau_eff);
        end
        OP_MUL_DLO: prod_q <= mul_p;
        OP_MUL_DHI: begin
          num_q  <= NumW'(prod_q);
          prod_q <= mul_p;
        end
        OP_ADD_HI: num_q <= num_q + {prod_q, {MulW{1'b0}}};
        default:   upd_q <= upd_q;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_upd_q <= upd_q;
      out_bx_q  <= s2_q[0];
      out_by_q  <= s2_q[1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_by_q, out_bx_q};
  assign m_axis_tuser  = out_upd_q;

  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (run_q && (pc_q == '0)))
    else $error("accepted beat did not start the program at its first step");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (run_q && (uw.op == OP_DIV_WAIT)))
    else $error("divider busy outside a wait step");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(run_q && (uw.op == OP_EMIT)))
    else $error("result beat appeared without an emit step");

endmodule

`default_nettype wire
